@@ rtl/core/sm3_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SM3 package
// Constants and round helper functions shared by the SM3 engine files.
// ----------------------------------------------------------------------------
package sm3_pkg;

   localparam logic [31:0] T_LOW  = 32'h79cc4519;
   localparam logic [31:0] T_HIGH = 32'h7a879d8a;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   typedef logic [7:0][31:0] chain_type;

   localparam chain_type IV = {32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
                               32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f};

   // compression core control
   typedef struct packed {
      logic start;
   } core_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } core_sts_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic logic [31:0] p0(input logic [31:0] x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic logic [31:0] p1(input logic [31:0] x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/sm3_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SM3 compression core
// Runs one 64-round compression. Message words come in as 16 big-endian
// words; expansion keeps a 16-word sliding window, one round per cycle.
// ----------------------------------------------------------------------------
module sm3_core (
   input  wire                         clock,
   input  wire                         reset,
   input  wire sm3_pkg::core_ctl_type  ctl,
   input  wire [15:0][31:0]            block_words,
   input  wire sm3_pkg::chain_type     chain_in,
   output sm3_pkg::chain_type          chain_out,
   output sm3_pkg::core_sts_type       sts
);

   logic [15:0][31:0] win_ff, win_in;
   logic [7:0][31:0]  reg_ff, reg_in;
   logic [6:0]        round_ff, round_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [31:0] w_new, wj, wpj, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
   logic [5:0]  rj;

   always_comb begin
      rj    = round_ff[5:0];
      w_new = sm3_pkg::p1(win_ff[0] ^ win_ff[7] ^ sm3_pkg::rotl(win_ff[13], 5'd15))
              ^ sm3_pkg::rotl(win_ff[3], 5'd7) ^ win_ff[10];
      wj    = win_ff[0];
      wpj   = win_ff[0] ^ win_ff[4];
      tj    = (rj < 6'd16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
      a12   = sm3_pkg::rotl(reg_ff[0], 5'd12);
      ss1   = sm3_pkg::rotl(a12 + reg_ff[4] + sm3_pkg::rotl(tj, rj[4:0]), 5'd7);
      ss2   = ss1 ^ a12;
      if (rj < 6'd16) begin
         ff = reg_ff[0] ^ reg_ff[1] ^ reg_ff[2];
         gg = reg_ff[4] ^ reg_ff[5] ^ reg_ff[6];
      end else begin
         ff = (reg_ff[0] & reg_ff[1]) | (reg_ff[0] & reg_ff[2]) | (reg_ff[1] & reg_ff[2]);
         gg = (reg_ff[4] & reg_ff[5]) | (~reg_ff[4] & reg_ff[6]);
      end
      tt1 = ff + reg_ff[3] + ss2 + wpj;
      tt2 = gg + reg_ff[7] + ss1 + wj;
   end

   // round sequencing
   always_comb begin
      win_in   = win_ff;
      reg_in   = reg_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (ctl.start && !busy_ff) begin
         win_in   = block_words;
         reg_in   = chain_in;
         round_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         win_in = {w_new, win_ff[15:1]};
         reg_in = {reg_ff[6], sm3_pkg::rotl(reg_ff[5], 5'd19), reg_ff[4], sm3_pkg::p0(tt2),
                   reg_ff[2], sm3_pkg::rotl(reg_ff[1], 5'd9), reg_ff[0], tt1};
         reg_in = {reg_in[7], reg_in[6], reg_in[5], reg_in[4],
                   reg_in[3], reg_in[2], reg_in[1], reg_in[0]};
         round_in = round_ff + 7'd1;
         if (round_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff   <= win_in;
      reg_ff   <= reg_in;
      round_ff <= round_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_comb begin
      for (int k = 0; k < 8; k++) chain_out[k] = chain_in[k] ^ reg_ff[k];
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule
`default_nettype wire

@@ rtl/core/sm3_hash_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A byte that does not fill a block is only written to the buffer; a byte that fills
// a block starts the buffer reads and then a compression.
// A last beat adds up to 64 padding writes per block and one or two
// compressions, then 8 digest beats.
// No byte is taken while a block is read or compressed; the core runs one round per cycle.
// Synchronous reset loads the SM3 initial value and clears counts.
// ----------------------------------------------------------------------------
// SM3 hash engine
// Byte-stream SM3 hasher with a 64-byte buffer memory and digest output.
// ----------------------------------------------------------------------------
module sm3_hash_engine (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [7:0]   req_tdata,   // [7:0] data_byte
   input  wire         req_tuser,   // byte_present
   input  wire         req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
   output logic        rsp_tlast    // last_word
);

   localparam logic [3:0] ST_IDLE = 4'd0, ST_LOAD = 4'd1, ST_RUN = 4'd2,
                          ST_PAD = 4'd3, ST_LEN = 4'd4, ST_OUT = 4'd5;

   logic [3:0]  state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic        final_ff, final_in;  // finishing message
   logic        two_ff, two_in;      // first of two final blocks
   logic        lenw_ff, lenw_in;    // length field written
   logic [4:0]  cnt_ff, cnt_in;
   logic [2:0]  oidx_ff, oidx_in;
   sm3_pkg::chain_type chain_ff, chain_in;
   logic [15:0][31:0]  words_ff, words_in;

   // block buffer memory: 16 words, byte write enables, byte 0 in the top lane
   logic [3:0][7:0] mem [16];
   logic        we;
   logic [5:0]  waddr;
   logic [7:0]  wdata;
   logic [3:0]  raddr;
   logic [31:0] rdata_ff;

   sm3_pkg::core_ctl_type ctl;
   sm3_pkg::core_sts_type sts;
   sm3_pkg::chain_type    chain_new;

   sm3_core u_core (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .block_words (words_ff),
      .chain_in    (chain_ff),
      .chain_out   (chain_new),
      .sts         (sts)
   );

   always_ff @(posedge clock) begin
      if (we) mem[waddr[5:2]][~waddr[1:0]] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign req_tready = (state_ff == ST_IDLE);

   // control sequencer
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      bits_in  = bits_ff;
      final_in = final_ff;
      two_in   = two_ff;
      lenw_in  = lenw_ff;
      cnt_in   = cnt_ff;
      oidx_in  = oidx_ff;
      chain_in = chain_ff;
      words_in = words_ff;
      we       = 1'b0;
      waddr    = fill_ff;
      wdata    = req_tdata;
      raddr    = cnt_ff[3:0];
      ctl.start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               final_in = req_tlast;
               lenw_in  = 1'b0;
               cnt_in   = '0;
               if (req_tuser) begin
                  we      = 1'b1;
                  fill_in = fill_ff + 6'd1;
                  bits_in = bits_ff + 64'd8;
                  if (fill_ff == 6'd63) begin
                     state_in = ST_LOAD;
                     two_in   = 1'b0;
                  end else if (req_tlast) begin
                     state_in = ST_PAD;
                  end
               end else if (req_tlast) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // pad byte then zeros up to the block end or the length field
            we    = 1'b1;
            waddr = fill_ff;
            wdata = (cnt_ff == 5'd0) ? sm3_pkg::PAD_BYTE : 8'd0;
            cnt_in  = 5'd1;
            fill_in = fill_ff + 6'd1;
            if (fill_ff == 6'd63) begin
               state_in = ST_LOAD;
               two_in   = 1'b1;
               cnt_in   = '0;
            end else if (fill_ff == 6'd55) begin
               state_in = ST_LEN;
               cnt_in   = '0;
            end
         end
         ST_LEN: begin
            we    = 1'b1;
            waddr = {3'b111, cnt_ff[2:0]};
            wdata = bits_ff[8*(7 - cnt_ff[2:0]) +: 8];
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd7) begin
               state_in = ST_LOAD;
               two_in   = 1'b0;
               lenw_in  = 1'b1;
               cnt_in   = '0;
            end
         end
         ST_LOAD: begin
            // read 16 words, registered data lands in the next cycle; start once all are held
            if (cnt_ff == 5'd17) begin
               state_in  = ST_RUN;
               ctl.start = 1'b1;
            end else begin
               if (cnt_ff != 5'd0) words_in[4'(cnt_ff - 5'd1)] = rdata_ff;
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ST_RUN: begin
            if (sts.done) begin
               chain_in = chain_new;
               fill_in  = '0;
               cnt_in   = '0;
               if (!final_ff) state_in = ST_IDLE;
               else if (lenw_ff) begin
                  state_in = ST_OUT;
                  oidx_in  = '0;
               end else state_in = ST_PAD;
               if (two_ff) cnt_in = 5'd1;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  state_in = ST_IDLE;
                  chain_in = sm3_pkg::IV;
                  bits_in  = '0;
                  fill_in  = '0;
                  final_in = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      words_ff <= words_in;
      two_ff   <= two_in;
      lenw_ff  <= lenw_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         bits_ff  <= '0;
         final_ff <= 1'b0;
         oidx_ff  <= '0;
         chain_ff <= sm3_pkg::IV;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
         final_ff <= final_in;
         oidx_ff  <= oidx_in;
         chain_ff <= chain_in;
      end
   end

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {5'd0, oidx_ff, chain_ff[oidx_ff]};
   assign rsp_tlast  = (oidx_ff == 3'd7);

   // no input taken while a compression runs
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      sts.busy |-> !req_tready) else $error("input accepted during compression");
   // digest only after a final block
   a_out_final: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> final_ff) else $error("digest without final beat");
   // core start only from buffer load
   a_start: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> (state_ff == ST_LOAD) && !sts.busy) else $error("bad core start");

endmodule
`default_nettype wire
